// ----- design/pidsc_pkg.sv -----
// ----------------------------------------------------------------------------
// pidsc_pkg
// Shared types and constants for the PID speed controller: the control
// word format, datapath opcodes, gain selects and register indexes.
// ----------------------------------------------------------------------------
package pidsc_pkg;

  // Field widths
  localparam int unsigned SpeedW = 16;  // setpoint / measured
  localparam int unsigned ErrW   = 17;  // setpoint - measured
  localparam int unsigned GainW  = 16;  // Q8.8 gains and integration time
  localparam int unsigned LimW   = 31;  // magnitude limits
  localparam int unsigned DriveW = 32;  // drive and integrator
  localparam int unsigned OpaW   = 25;  // multiplier signed operand
  localparam int unsigned ProdW  = 42;  // OpaW x (GainW+1)
  localparam int unsigned SumW   = 34;  // running sum before a clamp
  localparam int unsigned FracW  = 8;   // Q8.8 fraction bits
  localparam int unsigned PcW    = 4;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_TIME = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_LIM  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OUT_LIM    = 3'd5;

  typedef logic [PcW-1:0] pc_t;

  // Jump targets in the control program
  localparam pc_t PC_CLAMP_I = 4'd6;
  localparam pc_t PC_DERIV   = 4'd10;
  localparam pc_t PC_OUT     = 4'd13;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,  // err = sp - meas, sum = integrator
    OP_A_ERR   = 3'd1,  // operand = err
    OP_A_PROD  = 3'd2,  // operand = product >>> 8
    OP_A_DIFF  = 3'd3,  // operand = err - prev_err, prev_err = err
    OP_MUL     = 3'd4,  // product = operand * gain
    OP_ADD     = 3'd5,  // sum += product >>> 8
    OP_CLAMP_I = 3'd6,  // sum = clamp(sum, integral limit), store integrator
    OP_CLAMP_O = 3'd7   // drive = clamp(sum, output limit)
  } op_e;

  // Multiplier gain operand
  typedef enum logic [1:0] {
    GSEL_P = 2'd0,
    GSEL_I = 2'd1,
    GSEL_D = 2'd2,
    GSEL_T = 2'd3
  } gsel_e;

  // One control word of the program
  typedef struct packed {
    op_e   op;
    gsel_e gsel;
    logic  jz;      // jump to target when the selected gain is zero
    pc_t   target;
    logic  last;
  } ucode_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic  start;   // input beat accepted, latch payload
    logic  exec;    // current control word executes this cycle
    op_e   op;
    gsel_e gsel;
  } ctrl_t;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [GainW-1:0] prop_gain;
    logic [GainW-1:0] integ_gain;
    logic [GainW-1:0] deriv_gain;
    logic [GainW-1:0] integ_time;
    logic [LimW-1:0]  integral_limit;
    logic [LimW-1:0]  output_limit;
  } cfg_t;

endpackage

// ----- design/pidsc_seq.sv -----
// ----------------------------------------------------------------------------
// pidsc_seq
// Control sequencer: program ROM, step counter with conditional jump,
// input handshake and result-valid flag.
// ----------------------------------------------------------------------------
module pidsc_seq import pidsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  logic  gain_zero_i,
  output ctrl_t ctrl_o
);

  logic   busy_q, busy_d;
  pc_t    pc_q, pc_d;
  logic   ovalid_q, ovalid_d;
  ucode_t uw;
  logic   start, stall, exec;

  // Control program
  always_comb begin
    case (pc_q)
      4'd0:  uw = '{op: OP_LOAD,    gsel: GSEL_I, jz: 1'b1, target: PC_CLAMP_I, last: 1'b0};
      4'd1:  uw = '{op: OP_A_ERR,   gsel: GSEL_I, jz: 1'b0, target: '0,         last: 1'b0};
      4'd2:  uw = '{op: OP_MUL,     gsel: GSEL_I, jz: 1'b0, target: '0,         last: 1'b0};
      4'd3:  uw = '{op: OP_A_PROD,  gsel: GSEL_T, jz: 1'b0, target: '0,         last: 1'b0};
      4'd4:  uw = '{op: OP_MUL,     gsel: GSEL_T, jz: 1'b0, target: '0,         last: 1'b0};
      4'd5:  uw = '{op: OP_ADD,     gsel: GSEL_T, jz: 1'b0, target: '0,         last: 1'b0};
      4'd6:  uw = '{op: OP_CLAMP_I, gsel: GSEL_I, jz: 1'b0, target: '0,         last: 1'b0};
      4'd7:  uw = '{op: OP_A_ERR,   gsel: GSEL_P, jz: 1'b1, target: PC_DERIV,   last: 1'b0};
      4'd8:  uw = '{op: OP_MUL,     gsel: GSEL_P, jz: 1'b0, target: '0,         last: 1'b0};
      4'd9:  uw = '{op: OP_ADD,     gsel: GSEL_P, jz: 1'b0, target: '0,         last: 1'b0};
      4'd10: uw = '{op: OP_A_DIFF,  gsel: GSEL_D, jz: 1'b1, target: PC_OUT,     last: 1'b0};
      4'd11: uw = '{op: OP_MUL,     gsel: GSEL_D, jz: 1'b0, target: '0,         last: 1'b0};
      4'd12: uw = '{op: OP_ADD,     gsel: GSEL_D, jz: 1'b0, target: '0,         last: 1'b0};
      default: uw = '{op: OP_CLAMP_O, gsel: GSEL_P, jz: 1'b0, target: '0,       last: 1'b1};
    endcase
  end

  // Handshake and step enable; the final step waits for the output register
  assign start = in_valid_i && !busy_q;
  assign stall = uw.last && ovalid_q && !out_ready_i;
  assign exec  = busy_q && !stall;

  // Next state
  always_comb begin
    busy_d   = busy_q;
    pc_d     = pc_q;
    ovalid_d = ovalid_q;
    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    if (start) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (exec) begin
      if (uw.last) begin
        busy_d   = 1'b0;
        ovalid_d = 1'b1;
      end else if (uw.jz && gain_zero_i) begin
        pc_d = uw.target;
      end else begin
        pc_d = pc_q + pc_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pc_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      pc_q     <= pc_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = !busy_q;
  assign out_valid_o = ovalid_q;

  assign ctrl_o.start = start;
  assign ctrl_o.exec  = exec;
  assign ctrl_o.op    = uw.op;
  assign ctrl_o.gsel  = uw.gsel;

endmodule

// ----- design/pidsc_dp.sv -----
// ----------------------------------------------------------------------------
// pidsc_dp
// PID datapath: one shared multiplier, a running sum with symmetric
// clamp, the integrator and previous-error state, and the drive register.
// ----------------------------------------------------------------------------
module pidsc_dp import pidsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_t                    ctrl_i,
  input  cfg_t                     cfg_i,
  input  logic signed [SpeedW-1:0] setpoint_i,
  input  logic signed [SpeedW-1:0] measured_i,
  output logic                     gain_zero_o,
  output logic signed [DriveW-1:0] drive_o
);

  logic signed [SpeedW-1:0] sp_q, ms_q;
  logic signed [ErrW-1:0]   err_q, prev_err_q;
  logic signed [DriveW-1:0] integ_q, drive_q;
  logic signed [OpaW-1:0]   opa_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [SumW-1:0]   sum_q;

  logic [GainW-1:0]         gain;
  logic signed [ProdW-1:0]  mul;
  logic signed [ErrW:0]     diff;
  logic signed [SumW-1:0]   prod_sh;
  logic [LimW-1:0]          lim;
  logic signed [SumW-1:0]   lim_pos, lim_neg, clamped;
  logic signed [ErrW-1:0]   err_new;

  function automatic logic signed [ErrW-1:0] setpoint_q_ext(logic signed [SpeedW-1:0] v);
    setpoint_q_ext = {v[SpeedW-1], v};
  endfunction

  // Gain operand select
  always_comb begin
    case (ctrl_i.gsel)
      GSEL_P:  gain = cfg_i.prop_gain;
      GSEL_I:  gain = cfg_i.integ_gain;
      GSEL_D:  gain = cfg_i.deriv_gain;
      GSEL_T:  gain = cfg_i.integ_time;
      default: gain = cfg_i.prop_gain;
    endcase
  end
  assign gain_zero_o = (gain == '0);

  // Shared multiplier, signed operand times unsigned gain
  assign mul     = $signed(opa_q) * $signed({1'b0, gain});
  assign prod_sh = prod_q[ProdW-1:FracW];
  assign diff    = {err_q[ErrW-1], err_q} - {prev_err_q[ErrW-1], prev_err_q};
  assign err_new = {setpoint_q_ext(sp_q)} - {setpoint_q_ext(ms_q)};

  // Symmetric clamp against the selected limit
  assign lim     = (ctrl_i.op == OP_CLAMP_I) ? cfg_i.integral_limit : cfg_i.output_limit;
  assign lim_pos = $signed({{(SumW-LimW){1'b0}}, lim});
  assign lim_neg = -lim_pos;
  always_comb begin
    if (sum_q > lim_pos) begin
      clamped = lim_pos;
    end else if (sum_q < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = sum_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      sp_q <= setpoint_i;
      ms_q <= measured_i;
    end
    if (ctrl_i.exec) begin
      case (ctrl_i.op)
        OP_LOAD: begin
          err_q <= err_new;
          sum_q <= SumW'(integ_q);
        end
        OP_A_ERR:   opa_q  <= OpaW'(err_q);
        OP_A_PROD:  opa_q  <= prod_q[OpaW+FracW-1:FracW];
        OP_A_DIFF:  opa_q  <= OpaW'(diff);
        OP_MUL:     prod_q <= mul;
        OP_ADD:     sum_q  <= sum_q + prod_sh;
        OP_CLAMP_I: sum_q  <= clamped;
        OP_CLAMP_O: drive_q <= clamped[DriveW-1:0];
        default: ;
      endcase
    end
  end

  // Loop state across periods
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      prev_err_q <= '0;
    end else if (ctrl_i.exec) begin
      if (ctrl_i.op == OP_CLAMP_I) begin
        integ_q <= clamped[DriveW-1:0];
      end
      if (ctrl_i.op == OP_A_DIFF) begin
        prev_err_q <= err_q;
      end
    end
  end

  assign drive_o = drive_q;

endmodule

// ----- design/pid_speed_controller_core.sv -----
// ----------------------------------------------------------------------------
// pid_speed_controller_core
// PID speed controller with clamped integrator, run by a small control
// program over one shared multiplier.
// ----------------------------------------------------------------------------
//  Channel | Signals                               | Dir | Beat
//  in      | in_valid_i in_ready_o setpoint_i      | in  | one control period
//          | measured_i                            |     |
//  out     | out_valid_o out_ready_i drive_o       | out | one drive value
//  cfg     | cfg_we_i cfg_idx_i cfg_data_i         | in  | one register write
//
//  An item runs 5 to 14 program steps after its accept cycle; each nonzero
//  gain adds its multiply steps on the single shared multiplier. The next
//  item can be taken in the cycle after the final step.
//  Reset (async, active low) clears the integrator, previous error and
//  loads the default configuration.
//  A result waiting in the output register holds only the final step of the
//  following item.
// ----------------------------------------------------------------------------
module pid_speed_controller_core import pidsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [SpeedW-1:0] setpoint_i,
  input  logic signed [SpeedW-1:0] measured_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DriveW-1:0] drive_o,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [LimW-1:0]          cfg_data_i
);

  cfg_t  cfg_q;
  ctrl_t ctrl;
  logic  gain_zero;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= '0;
      cfg_q.integ_gain     <= '0;
      cfg_q.deriv_gain     <= '0;
      cfg_q.integ_time     <= GainW'(256);
      cfg_q.integral_limit <= LimW'(32767);
      cfg_q.output_limit   <= LimW'(32767);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROP_GAIN:  cfg_q.prop_gain      <= cfg_data_i[GainW-1:0];
        CFG_INTEG_GAIN: cfg_q.integ_gain     <= cfg_data_i[GainW-1:0];
        CFG_DERIV_GAIN: cfg_q.deriv_gain     <= cfg_data_i[GainW-1:0];
        CFG_INTEG_TIME: cfg_q.integ_time     <= cfg_data_i[GainW-1:0];
        CFG_INTEG_LIM:  cfg_q.integral_limit <= cfg_data_i;
        CFG_OUT_LIM:    cfg_q.output_limit   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pidsc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .gain_zero_i (gain_zero),
    .ctrl_o      (ctrl)
  );

  pidsc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg_q),
    .setpoint_i  (setpoint_i),
    .measured_i  (measured_i),
    .gain_zero_o (gain_zero),
    .drive_o     (drive_o)
  );

endmodule

// ----- design/pidsc_chk.sv -----
// ----------------------------------------------------------------------------
// pidsc_chk
// Port-level checks for the PID speed controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidsc_chk import pidsc_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DriveW-1:0] drive_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_o))
    else $error("result beat changed while stalled");

  // An accepted item keeps the block busy for at least one step
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after accept");

  // The block frees up only when it has a result to show
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("block went idle without a result");

  // Symmetric clamp never yields the most negative value
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_o != {1'b1, {(DriveW-1){1'b0}}})
    else $error("drive outside clamp range");

endmodule

bind pid_speed_controller_core pidsc_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .drive_o     (drive_o)
);
